[hdl/thri_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thri_pkg
// Shared types and constants of the humidity ratio interpolator.
// ----------------------------------------------------------------------------
package thri_pkg;

   localparam int TEMP_W   = 8;
   localparam int RATIO_W  = 16;
   localparam int ROWIDX_W = 4;
   localparam int HUM_W    = 7;
   localparam int ROWS_W   = 5;
   localparam int CSR_W    = 7;
   localparam int CSR_IDX_W = 2;

   // arithmetic widths
   localparam int ACC_W   = 36;   // products, quotients and partial results
   localparam int MUL_A_W = 27;   // slope or ratio difference
   localparam int MUL_B_W = 9;    // temperature or humidity offset
   localparam int DEN_W   = 9;    // divisor

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HUMIDITY_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HUMIDITY_HIGH = 2'd2;

   localparam logic [ROWS_W-1:0] ROWS_RESET    = 5'd16;
   localparam logic [HUM_W-1:0]  HUM_LOW_RESET  = 7'd33;
   localparam logic [HUM_W-1:0]  HUM_HIGH_RESET = 7'd85;

   typedef struct packed {
      logic [TEMP_W-1:0]  temp;
      logic [RATIO_W-1:0] ratio_low;
      logic [RATIO_W-1:0] ratio_high;
   } row_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CHECK,
      ST_DIV_LO,
      ST_MUL_LO,
      ST_ADD_LO,
      ST_DIV_HI,
      ST_MUL_HI,
      ST_ADD_HI,
      ST_HUM_MUL,
      ST_HUM_DIV,
      ST_FINISH
   } state_type;

endpackage

[hdl/thri_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thri_req_if / thri_rsp_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface thri_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  action;
   logic        [thri_pkg::ROWIDX_W-1:0]  row_index;
   logic signed [thri_pkg::TEMP_W-1:0]    row_temp;
   logic        [thri_pkg::RATIO_W-1:0]   row_ratio_low;
   logic        [thri_pkg::RATIO_W-1:0]   row_ratio_high;
   logic signed [thri_pkg::TEMP_W-1:0]    query_temp;
   logic        [thri_pkg::HUM_W-1:0]     query_humidity;

   modport source (
      output valid, action, row_index, row_temp, row_ratio_low, row_ratio_high,
             query_temp, query_humidity,
      input  ready
   );
   modport sink (
      input  valid, action, row_index, row_temp, row_ratio_low, row_ratio_high,
             query_temp, query_humidity,
      output ready
   );
endinterface

interface thri_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [thri_pkg::RATIO_W-1:0]    ratio;
   logic                            fault;

   modport source (output valid, ratio, fault, input ready);
   modport sink (input valid, ratio, fault, output ready);
endinterface

[hdl/temp_humidity_ratio_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_humidity_ratio_interpolator
// Compensation table with piecewise linear interpolation in temperature and
// then in humidity, saturated to 16 bits, fault on a zero divisor.
// ----------------------------------------------------------------------------
// channel   dir  handshake         payload
// req_bus   in   valid / ready     action, row_index, row_temp, row_ratio_low,
//                                  row_ratio_high, query_temp, query_humidity
// rsp_bus   out  valid / ready     ratio, fault
// csr_*     in   csr_we            csr_index, csr_wdata
//
// a write beat is taken in idle and leaves the block ready; a query fetches
// and checks one row at a time, then runs three divides on the shared
// divider when it lies between two rows, or one at a table edge
// synchronous reset clears the sequencer and the result valid and loads the csrs with their defaults;
// table rows hold garbage until written
// a finished result waits in the output register; ready comes back as soon
// as that register is loaded, a stalled rsp holds the next query in its
// last cycle
// ----------------------------------------------------------------------------
module temp_humidity_ratio_interpolator #(
   parameter int TABLE_ROWS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [thri_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [thri_pkg::CSR_W-1:0]         csr_wdata,
   thri_req_if.sink                           req_bus,
   thri_rsp_if.source                         rsp_bus
);

   localparam int AW = $clog2(TABLE_ROWS);
   localparam int CW = $clog2(TABLE_ROWS + 1);
   localparam int ACC_W = thri_pkg::ACC_W;
   localparam int MA_W  = thri_pkg::MUL_A_W;
   localparam int MB_W  = thri_pkg::MUL_B_W;
   localparam int DEN_W = thri_pkg::DEN_W;
   localparam int RW    = thri_pkg::RATIO_W;
   localparam int TW    = thri_pkg::TEMP_W;

   thri_pkg::state_type state_ff, state_in;

   // csrs
   logic [thri_pkg::ROWS_W-1:0] rows_ff;
   logic [thri_pkg::HUM_W-1:0]  hum_lo_ff;
   logic [thri_pkg::HUM_W-1:0]  hum_hi_ff;

   // query context
   logic signed [TW-1:0]         qt_ff, qt_in;
   logic [thri_pkg::HUM_W-1:0]   qh_ff, qh_in;
   logic [CW-1:0]                n_ff, n_in;
   logic [CW-1:0]                idx_ff, idx_in;
   thri_pkg::row_type            cur_ff, cur_in;
   thri_pkg::row_type            prv_ff, prv_in;
   logic signed [ACC_W-1:0]      r1_ff, r1_in;
   logic signed [ACC_W-1:0]      r2_ff, r2_in;
   logic signed [ACC_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]      res_ff, res_in;
   logic                         fault_ff, fault_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]                rsp_ratio_ff, rsp_ratio_in;
   logic                         rsp_fault_ff, rsp_fault_in;

   // control outputs
   logic                         req_fire;
   logic                         ram_we;
   logic                         div_start;
   logic                         out_load;

   // table
   thri_pkg::row_type            wr_row;
   thri_pkg::row_type            rd_row;
   logic [$bits(thri_pkg::row_type)-1:0] rd_bits;

   // shared units
   logic signed [ACC_W-1:0]      div_num;
   logic signed [DEN_W-1:0]      div_den;
   logic signed [ACC_W-1:0]      div_q;
   thri_pkg::div_stat_type       div_stat;
   logic signed [MA_W-1:0]       mul_a;
   logic signed [MB_W-1:0]       mul_b;
   logic signed [ACC_W-1:0]      mul_p;

   // derived values
   logic                         row_above;
   logic [CW-1:0]                idx_nx;
   logic signed [DEN_W-1:0]      dt_row;
   logic signed [DEN_W-1:0]      dt_cur;
   logic signed [MB_W-1:0]       dq;
   logic signed [RW:0]           dr_lo;
   logic signed [RW:0]           dr_hi;
   logic signed [MA_W-1:0]       dr_hum;
   logic signed [MB_W-1:0]       dh_q;
   logic signed [DEN_W-1:0]      dh_ref;
   logic [8:0]                   rows_wide;
   logic [8:0]                   n_wide;
   logic [RW-1:0]                res_sat;

   assign req_fire = req_bus.valid && req_bus.ready;

   assign wr_row.temp       = req_bus.row_temp;
   assign wr_row.ratio_low  = req_bus.row_ratio_low;
   assign wr_row.ratio_high = req_bus.row_ratio_high;
   assign rd_row            = rd_bits;

   thri_ram #(
      .WIDTH ($bits(thri_pkg::row_type)),
      .DEPTH (TABLE_ROWS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(req_bus.row_index)),
      .wr_data (wr_row),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_bits)
   );

   thri_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_q),
      .status   (div_stat)
   );

   // derived values
   always_comb begin
      row_above = qt_ff > $signed(rd_row.temp);
      idx_nx    = idx_ff + CW'(1);
      dt_row    = $signed({rd_row.temp[TW-1], rd_row.temp})
                - $signed({prv_ff.temp[TW-1], prv_ff.temp});
      dt_cur    = $signed({cur_ff.temp[TW-1], cur_ff.temp})
                - $signed({prv_ff.temp[TW-1], prv_ff.temp});
      dq        = $signed({qt_ff[TW-1], qt_ff})
                - $signed({cur_ff.temp[TW-1], cur_ff.temp});
      dr_lo     = $signed({1'b0, cur_ff.ratio_low}) - $signed({1'b0, prv_ff.ratio_low});
      dr_hi     = $signed({1'b0, cur_ff.ratio_high}) - $signed({1'b0, prv_ff.ratio_high});
      dr_hum    = r2_ff[MA_W-1:0] - r1_ff[MA_W-1:0];
      dh_q      = $signed({2'b00, qh_ff}) - $signed({2'b00, hum_lo_ff});
      dh_ref    = $signed({2'b00, hum_hi_ff}) - $signed({2'b00, hum_lo_ff});
      rows_wide = {4'b0000, rows_ff};
      if (rows_wide == 9'd0) begin
         n_wide = 9'd1;
      end else if (rows_wide > 9'(TABLE_ROWS)) begin
         n_wide = 9'(TABLE_ROWS);
      end else begin
         n_wide = rows_wide;
      end
      if (res_ff < 0) begin
         res_sat = '0;
      end else if (res_ff > $signed(ACC_W'(65535))) begin
         res_sat = '1;
      end else begin
         res_sat = res_ff[RW-1:0];
      end
   end

   // shared divider and multiplier operands
   always_comb begin
      div_num = prod_ff;
      div_den = dh_ref;
      mul_a   = dr_hum;
      mul_b   = dh_q;
      unique case (state_ff)
         thri_pkg::ST_DIV_LO: begin
            div_num = {{(ACC_W-RW-1){dr_lo[RW]}}, dr_lo};
            div_den = dt_cur;
         end
         thri_pkg::ST_DIV_HI: begin
            div_num = {{(ACC_W-RW-1){dr_hi[RW]}}, dr_hi};
            div_den = dt_cur;
         end
         thri_pkg::ST_MUL_LO, thri_pkg::ST_MUL_HI: begin
            mul_a = div_q[MA_W-1:0];
            mul_b = dq;
         end
         default: begin
         end
      endcase
   end

   assign mul_p = ACC_W'(mul_a) * ACC_W'(mul_b);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         thri_pkg::ST_IDLE: begin
            if (req_fire && req_bus.action == thri_pkg::ACT_QUERY) begin
               state_in = thri_pkg::ST_FETCH;
            end
         end
         thri_pkg::ST_FETCH: state_in = thri_pkg::ST_CHECK;
         thri_pkg::ST_CHECK: begin
            if (row_above) begin
               state_in = (idx_nx == n_ff) ? thri_pkg::ST_HUM_MUL : thri_pkg::ST_FETCH;
            end else if (idx_ff == '0) begin
               state_in = thri_pkg::ST_HUM_MUL;
            end else if (dt_row == '0) begin
               state_in = thri_pkg::ST_FINISH;
            end else begin
               state_in = thri_pkg::ST_DIV_LO;
            end
         end
         thri_pkg::ST_DIV_LO: begin
            if (div_stat.done) begin
               state_in = thri_pkg::ST_MUL_LO;
            end
         end
         thri_pkg::ST_MUL_LO: state_in = thri_pkg::ST_ADD_LO;
         thri_pkg::ST_ADD_LO: state_in = thri_pkg::ST_DIV_HI;
         thri_pkg::ST_DIV_HI: begin
            if (div_stat.done) begin
               state_in = thri_pkg::ST_MUL_HI;
            end
         end
         thri_pkg::ST_MUL_HI: state_in = thri_pkg::ST_ADD_HI;
         thri_pkg::ST_ADD_HI: state_in = thri_pkg::ST_HUM_MUL;
         thri_pkg::ST_HUM_MUL: begin
            state_in = (dh_ref == '0) ? thri_pkg::ST_FINISH : thri_pkg::ST_HUM_DIV;
         end
         thri_pkg::ST_HUM_DIV: begin
            if (div_stat.done) begin
               state_in = thri_pkg::ST_FINISH;
            end
         end
         thri_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = thri_pkg::ST_IDLE;
            end
         end
         default: state_in = thri_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_bus.ready = 1'b0;
      ram_we        = 1'b0;
      div_start     = 1'b0;
      out_load      = 1'b0;
      unique case (state_ff)
         thri_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            ram_we = req_bus.valid && req_bus.action == thri_pkg::ACT_WRITE
                     && ({5'b00000, req_bus.row_index} < 9'(TABLE_ROWS));
         end
         thri_pkg::ST_DIV_LO, thri_pkg::ST_DIV_HI, thri_pkg::ST_HUM_DIV: begin
            div_start = !div_stat.busy && !div_stat.done;
         end
         thri_pkg::ST_FINISH: begin
            out_load = !rsp_valid_ff || rsp_bus.ready;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      qt_in    = qt_ff;
      qh_in    = qh_ff;
      n_in     = n_ff;
      idx_in   = idx_ff;
      cur_in   = cur_ff;
      prv_in   = prv_ff;
      r1_in    = r1_ff;
      r2_in    = r2_ff;
      prod_in  = prod_ff;
      res_in   = res_ff;
      fault_in = fault_ff;
      unique case (state_ff)
         thri_pkg::ST_IDLE: begin
            qt_in    = req_bus.query_temp;
            qh_in    = req_bus.query_humidity;
            n_in     = CW'(n_wide);
            idx_in   = '0;
            fault_in = 1'b0;
         end
         thri_pkg::ST_CHECK: begin
            if (row_above) begin
               prv_in = rd_row;
               idx_in = idx_nx;
               r1_in  = $signed({{(ACC_W-RW){1'b0}}, rd_row.ratio_low});
               r2_in  = $signed({{(ACC_W-RW){1'b0}}, rd_row.ratio_high});
            end else begin
               cur_in = rd_row;
               r1_in  = $signed({{(ACC_W-RW){1'b0}}, rd_row.ratio_low});
               r2_in  = $signed({{(ACC_W-RW){1'b0}}, rd_row.ratio_high});
               if (idx_ff != '0 && dt_row == '0) begin
                  fault_in = 1'b1;
               end
            end
         end
         thri_pkg::ST_MUL_LO, thri_pkg::ST_MUL_HI, thri_pkg::ST_HUM_MUL: begin
            prod_in = mul_p;
            if (state_ff == thri_pkg::ST_HUM_MUL && dh_ref == '0) begin
               fault_in = 1'b1;
            end
         end
         thri_pkg::ST_ADD_LO: begin
            r1_in = prod_ff + $signed({{(ACC_W-RW){1'b0}}, cur_ff.ratio_low});
         end
         thri_pkg::ST_ADD_HI: begin
            r2_in = prod_ff + $signed({{(ACC_W-RW){1'b0}}, cur_ff.ratio_high});
         end
         thri_pkg::ST_HUM_DIV: begin
            res_in = r1_ff + div_q;
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ratio_in = rsp_ratio_ff;
      rsp_fault_in = rsp_fault_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_ratio_in = fault_ff ? '0 : res_sat;
         rsp_fault_in = fault_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= thri_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= thri_pkg::ROWS_RESET;
         hum_lo_ff    <= thri_pkg::HUM_LOW_RESET;
         hum_hi_ff    <= thri_pkg::HUM_HIGH_RESET;
         fault_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fault_ff     <= fault_in;
         if (csr_we) begin
            unique case (csr_index)
               thri_pkg::CSR_ROWS_IN_USE:   rows_ff   <= csr_wdata[thri_pkg::ROWS_W-1:0];
               thri_pkg::CSR_HUMIDITY_LOW:  hum_lo_ff <= csr_wdata;
               thri_pkg::CSR_HUMIDITY_HIGH: hum_hi_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      qt_ff        <= qt_in;
      qh_ff        <= qh_in;
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      cur_ff       <= cur_in;
      prv_ff       <= prv_in;
      r1_ff        <= r1_in;
      r2_ff        <= r2_in;
      prod_ff      <= prod_in;
      res_ff       <= res_in;
      rsp_ratio_ff <= rsp_ratio_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.ratio = rsp_ratio_ff;
   assign rsp_bus.fault = rsp_fault_ff;

endmodule

[hdl/thri_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thri_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module thri_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/thri_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thri_div
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module thri_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [thri_pkg::ACC_W-1:0]    dividend,
   input  logic signed [thri_pkg::DEN_W-1:0]    divisor,
   output logic signed [thri_pkg::ACC_W-1:0]    quotient,
   output thri_pkg::div_stat_type               status
);

   localparam int AW = thri_pkg::ACC_W;
   localparam int DW = thri_pkg::DEN_W;
   localparam int CNT_W = $clog2(AW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    den_ff, den_in;
   logic             neg_ff, neg_in;

   logic [DW:0]      shifted;
   logic [DW:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff, quo_ff[AW-1]};
      trial   = shifted - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(AW);
         rem_in  = '0;
         quo_in  = dividend[AW-1] ? AW'(-dividend) : AW'(dividend);
         den_in  = divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
         neg_in  = dividend[AW-1] ^ divisor[DW-1];
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[AW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[AW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign quotient    = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[hdl/thri_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thri_chk
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module thri_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_action,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [thri_pkg::RATIO_W-1:0]  rsp_ratio,
   input logic                          rsp_fault
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ratio) && $stable(rsp_fault))
      else $error("stalled rsp beat changed");

   // a fault always forces the ratio to zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_ratio == '0)
      else $error("fault with nonzero ratio");

   // a query keeps the block busy for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == thri_pkg::ACT_QUERY |=> !req_ready)
      else $error("ready right after a query beat");

   // a table write never produces a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == thri_pkg::ACT_WRITE |=> !$rose(rsp_valid))
      else $error("result after a write beat");

endmodule

bind temp_humidity_ratio_interpolator thri_chk u_thri_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_action (req_bus.action),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_ratio  (rsp_bus.ratio),
   .rsp_fault  (rsp_bus.fault)
);
